// File: rtl/epx_pkg.sv
// shared types and constants for the epx 2x pixel upscaler
`timescale 1ns / 1ps

package epx_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int PIXEL_BITS = 32;
    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int DIM_BITS   = 11;
    localparam int CFG_BITS   = 1;

    typedef logic [PIXEL_BITS-1:0] pixel_t;
    typedef logic [COL_BITS-1:0]   col_t;
    typedef logic [DIM_BITS-1:0]   dim_t;
    typedef logic [CFG_BITS-1:0]   cfg_idx_t;

    // register indexes of the configuration port
    localparam cfg_idx_t REG_FRAME_WIDTH  = 1'b0;
    localparam cfg_idx_t REG_FRAME_HEIGHT = 1'b1;

    // input item kinds
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    localparam dim_t WIDTH_RESET  = DIM_BITS'(320);
    localparam dim_t HEIGHT_RESET = DIM_BITS'(224);

    // one 2x2 output block
    typedef struct packed {
        pixel_t top_left;
        pixel_t top_right;
        pixel_t bottom_left;
        pixel_t bottom_right;
        logic   end_of_frame;
    } epx_block_t;

endpackage

// File: rtl/epx_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module epx_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/epx_pixel_upscaler_2x_unit.sv
// top level of the epx (scale2x) 2x pixel upscaler
`timescale 1ns / 1ps

// EPX / Scale2x 2x upscaler. Source pixels (s_mode = 0) arrive in raster order
// for a frame of frame_width x frame_height; each becomes a 2x2 block that is
// sent when the pixel below it arrives, so row 0 gives no blocks. Once all rows
// are in, one flush transfer (s_mode = 1) per column sends the last row; the
// last flush block carries end_of_frame and the next pixel opens a new frame.
// Pixels sent while flush is pending, and flushes sent early, are taken and
// dropped. Neighbors outside the frame take the center value. A write to either
// register restarts the frame; write only while idle. Throughput is one
// transfer per clock while the skid entry is empty, set by the line stores:
// each transfer reads the entries for the next column ahead (single read
// port per ram), with the previous line held twice so the center and right
// neighbor come out together. Blocks go to the two-entry output stage: its head,
// or its skid entry while the head waits on m_ready, so one more transfer is
// taken while m_ready is low. Line stores need no clearing pass after reset.

module epx_pixel_upscaler_2x_unit (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  epx_pkg::cfg_idx_t  cfg_addr,
    input  epx_pkg::dim_t      cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  epx_pkg::pixel_t    s_pixel_in,

    output logic               m_valid,
    input  logic               m_ready,
    output epx_pkg::pixel_t    m_top_left,
    output epx_pkg::pixel_t    m_top_right,
    output epx_pkg::pixel_t    m_bottom_left,
    output epx_pkg::pixel_t    m_bottom_right,
    output logic               m_end_of_frame
);

    import epx_pkg::*;

    // configuration, held already clamped
    dim_t       width_reg, width_next;
    dim_t       height_reg, height_next;
    dim_t       cfg_width_eff, cfg_height_eff;

    // frame position
    col_t       col_reg, col_next;
    dim_t       row_reg, row_next;

    // left neighbor, last center used
    pixel_t     left_reg, left_next;

    // forwarding for reads that hit the entry written in the same cycle
    logic       fwd_c_reg, fwd_c_next;
    logic       fwd_r_reg, fwd_r_next;
    logic       fwd_u_reg, fwd_u_next;
    pixel_t     fwd_pix_reg, fwd_pix_next;
    pixel_t     fwd_ctr_reg, fwd_ctr_next;

    // output stage: head register plus skid entry
    epx_block_t out_reg, out_next;
    logic       out_valid_reg, out_valid_next;
    epx_block_t skid_reg, skid_next;
    logic       skid_valid_reg, skid_valid_next;

    // line store ports
    pixel_t     prev_c_q, prev_r_q, lbp_q;
    logic       prev_we, lbp_we, rd_en;
    col_t       rd_col, rd_col_r;

    // step decode
    logic       accept, rows_done, pix_step, fl_step, advance;
    logic       col_last, produce;
    col_t       col_plus;
    pixel_t     c_pix, u_pix, d_pix, l_pix, r_pix;
    pixel_t     u_raw, r_raw;
    logic       swap_ok;
    epx_block_t blk;
    logic       push, pop;

    // two copies of the previous line, one per read address
    epx_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_c (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (col_reg),
        .wdata (s_pixel_in),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (prev_c_q)
    );

    epx_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_r (
        .aclk  (aclk),
        .we    (prev_we),
        .waddr (col_reg),
        .wdata (s_pixel_in),
        .re    (rd_en),
        .raddr (rd_col_r),
        .rdata (prev_r_q)
    );

    // line before previous
    epx_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_lbp (
        .aclk  (aclk),
        .we    (lbp_we),
        .waddr (col_reg),
        .wdata (c_pix),
        .re    (rd_en),
        .raddr (rd_col),
        .rdata (lbp_q)
    );

    always_comb begin
        // clamp register writes
        if (cfg_wdata == '0) begin
            cfg_width_eff = DIM_BITS'(1);
        end else if (cfg_wdata > DIM_BITS'(MAX_WIDTH)) begin
            cfg_width_eff = DIM_BITS'(MAX_WIDTH);
        end else begin
            cfg_width_eff = cfg_wdata;
        end
        cfg_height_eff = (cfg_wdata == '0) ? DIM_BITS'(1) : cfg_wdata;

        s_ready   = !skid_valid_reg;
        accept    = s_valid && s_ready;
        rows_done = (row_reg >= height_reg);
        pix_step  = accept && (s_mode == MODE_PIXEL) && !rows_done;
        fl_step   = accept && (s_mode == MODE_FLUSH) && rows_done;
        advance   = pix_step || fl_step;

        col_last  = (({1'b0, col_reg} + DIM_BITS'(1)) == width_reg);
        col_plus  = col_reg + COL_BITS'(1);

        // window for the current column
        c_pix = fwd_c_reg ? fwd_pix_reg : prev_c_q;
        r_raw = fwd_r_reg ? fwd_pix_reg : prev_r_q;
        u_raw = fwd_u_reg ? fwd_ctr_reg : lbp_q;

        if (s_mode == MODE_PIXEL) begin
            u_pix = (row_reg >= DIM_BITS'(2)) ? u_raw : c_pix;
            d_pix = s_pixel_in;
        end else begin
            u_pix = (height_reg >= DIM_BITS'(2)) ? u_raw : c_pix;
            d_pix = c_pix;
        end
        l_pix = (col_reg != '0) ? left_reg : c_pix;
        r_pix = col_last ? c_pix : r_raw;

        // epx corner rule
        swap_ok = (l_pix != r_pix) && (u_pix != d_pix);
        blk.top_left     = (swap_ok && (u_pix == l_pix)) ? u_pix : c_pix;
        blk.top_right    = (swap_ok && (r_pix == u_pix)) ? r_pix : c_pix;
        blk.bottom_left  = (swap_ok && (l_pix == d_pix)) ? l_pix : c_pix;
        blk.bottom_right = (swap_ok && (d_pix == r_pix)) ? d_pix : c_pix;
        blk.end_of_frame = fl_step && col_last;

        produce = fl_step || (pix_step && (row_reg != '0));

        // store writes
        prev_we = pix_step;
        lbp_we  = pix_step && (row_reg != '0);

        // prefetch for the next column
        rd_en    = advance;
        rd_col   = col_last ? '0 : col_plus;
        rd_col_r = rd_col + COL_BITS'(1);

        fwd_c_next   = fwd_c_reg;
        fwd_r_next   = fwd_r_reg;
        fwd_u_next   = fwd_u_reg;
        fwd_pix_next = fwd_pix_reg;
        fwd_ctr_next = fwd_ctr_reg;
        if (rd_en) begin
            fwd_c_next   = prev_we && (rd_col == col_reg);
            fwd_r_next   = prev_we && (rd_col_r == col_reg);
            fwd_u_next   = lbp_we && (rd_col == col_reg);
            fwd_pix_next = s_pixel_in;
            fwd_ctr_next = c_pix;
        end

        // counters and configuration
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        left_next   = left_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  width_next  = cfg_width_eff;
                REG_FRAME_HEIGHT: height_next = cfg_height_eff;
                default:          width_next  = width_reg;
            endcase
            col_next = '0;
            row_next = '0;
        end else if (advance) begin
            left_next = c_pix;
            if (col_last) begin
                col_next = '0;
                // a pixel row ends, or the flush ends the frame
                row_next = pix_step ? (row_reg + DIM_BITS'(1)) : '0;
            end else begin
                col_next = col_plus;
            end
        end

        // output stage
        push = advance && produce;
        pop  = out_valid_reg && m_ready;

        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else begin
                out_next       = blk;
                out_valid_next = push;
            end
        end else if (push) begin
            skid_next       = blk;
            skid_valid_next = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg      <= WIDTH_RESET;
            height_reg     <= HEIGHT_RESET;
            col_reg        <= '0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            fwd_c_reg      <= 1'b0;
            fwd_r_reg      <= 1'b0;
            fwd_u_reg      <= 1'b0;
        end else begin
            width_reg      <= width_next;
            height_reg     <= height_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            fwd_c_reg      <= fwd_c_next;
            fwd_r_reg      <= fwd_r_next;
            fwd_u_reg      <= fwd_u_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        left_reg    <= left_next;
        fwd_pix_reg <= fwd_pix_next;
        fwd_ctr_reg <= fwd_ctr_next;
        out_reg     <= out_next;
        skid_reg    <= skid_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_top_left     = out_reg.top_left;
    assign m_top_right    = out_reg.top_right;
    assign m_bottom_left  = out_reg.bottom_left;
    assign m_bottom_right = out_reg.bottom_right;
    assign m_end_of_frame = out_reg.end_of_frame;

endmodule
